// ===== sv/grouping_partition_dp_macros.svh =====
// Assertion macros for the grouping partition block.
// Used by grouping_partition_dp.sv; needs i_clk and i_rst_n in scope.
`ifndef GROUPING_PARTITION_DP_MACROS_SVH
`define GROUPING_PARTITION_DP_MACROS_SVH

// same-cycle implication
`define GPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gpd_pkg.sv =====
// Shared types and constants of the grouping partition block.
// No dependencies.
package gpd_pkg;

    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int MAX_GROUPS_DEF = 16;
    localparam int SIZE_W         = 16;
    localparam int CFG_W          = 5;
    localparam int COST_W         = 32;
    localparam int COST_SENT      = 100000000;

    typedef struct packed {
        logic [SIZE_W-1:0] item_size;
        logic              last_item;
    } t_req;

    typedef struct packed {
        logic [SIZE_W-1:0] boundary_size;
        logic              last_boundary;
    } t_res;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_COL0 = 8'b0000_0010,
        S_COLS = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_COLW = 8'b0001_0000,
        S_TBS  = 8'b0010_0000,
        S_TB   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

endpackage

// ===== sv/gpd_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on gpd_pkg.
module gpd_ram
    import gpd_pkg::*;
#(
    parameter int DEPTH = MAX_ITEMS_DEF,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/grouping_partition_dp.sv =====
// Grouping partition top level: DP over stored items, traceback, result emit.
// Depends on gpd_pkg, gpd_ram and grouping_partition_dp_macros.svh.
//
//  channel | signals                        | handshake
//  --------+--------------------------------+------------------------------
//  request | i_req (item_size, last_item)   | i_start & !o_busy
//  result  | o_res (boundary_size, last_b.) | o_res_valid, one cycle, no stall
//  config  | i_cfg_data (group_count)       | i_cfg_valid & o_cfg_ready
//
// For item i, busy stays high through S_COL0, then per column k = 1..g-1 through S_COLS,
// S_SCAN (scan(k) split points, one per cycle via the cost RAM, then a pipe drain) and
// S_COLW; scan(k) is i - search_start[k]. Row zero skips S_SCAN. A last item adds a
// traceback, then the emit of each boundary; the final result is valid as busy falls.
// Reset (synchronous) clears control only; no RAM clearing pass is needed.
// Results are not held off by the receiver.
`include "grouping_partition_dp_macros.svh"

module grouping_partition_dp
    import gpd_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_req             i_req,
    output logic             o_res_valid,
    output t_res             o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int KW  = $clog2(MAX_GROUPS + 1);
    localparam int PW  = SIZE_W + IW;
    localparam int VW  = (PW + 3 > 34) ? PW + 3 : 34;
    localparam int IMW = SIZE_W + PW;
    localparam int DPW = 1 + IW + COST_W;
    localparam int DAW = IW + GW;

    localparam logic signed [VW-1:0] C_MAX  = VW'(64'sd2147483647);
    localparam logic signed [VW-1:0] C_MIN  = VW'(-64'sd2147483648);
    localparam logic signed [VW-1:0] C_SENT = VW'(COST_SENT);

    function automatic logic [COST_W-1:0] f_clamp(input logic signed [VW-1:0] v);
        logic [COST_W-1:0] res;
        if (v > C_MAX) begin
            res = C_MAX[COST_W-1:0];
        end else if (v < C_MIN) begin
            res = C_MIN[COST_W-1:0];
        end else begin
            res = v[COST_W-1:0];
        end
        return res;
    endfunction

    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_cfg;
    logic [KW-1:0]          r_g, n_g;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [IW-1:0]          r_row, n_row;
    logic [SIZE_W-1:0]      r_sz, n_sz;
    logic [PW-1:0]          r_pf, n_pf;
    logic                   r_last, n_last;
    logic [KW-1:0]          r_k, n_k;
    logic [IW-1:0]          r_j, n_j;
    logic                   r_p0, n_p0, r_p1, n_p1;
    logic [IW-1:0]          r_p0_j, n_p0_j, r_p1_j, n_p1_j;
    logic signed [VW-1:0]   r_v, n_v, r_best, n_best;
    logic [IW-1:0]          r_split, n_split;
    logic                   r_none, n_none;
    logic [IW-1:0]          r_ss [MAX_GROUPS];
    logic [KW-1:0]          r_tcnt, n_tcnt;
    logic                   r_push, n_push;
    logic [GW-1:0]          r_ridx, n_ridx;
    logic                   r_emit, r_emit_last;
    logic [SIZE_W-1:0]      r_buf_q;
    logic [SIZE_W-1:0]      r_tbuf [MAX_GROUPS];

    logic                   w_acc, w_issue, w_improve, w_stored;
    logic                   w_im_we, w_dp_we, w_tb_we;
    logic [IW-1:0]          w_im_raddr;
    logic [IMW-1:0]         w_im_wdata, w_im_q;
    logic [DAW-1:0]         w_dp_waddr, w_dp_raddr;
    logic [DPW-1:0]         w_dp_wdata, w_dp_q;
    logic [GW-1:0]          w_tb_waddr;
    logic [SIZE_W-1:0]      w_tb_wdata;
    logic [KW-1:0]          w_tcnt_now;
    logic [SIZE_W+CW-1:0]   w_c0_prod;
    logic signed [VW-1:0]   w_c0, w_v;
    logic [PW-1:0]          w_pad_prod, w_pf_new;
    logic [IW-1:0]          w_pos;
    logic                   w_pos_none;
    logic [KW-1:0]          w_kdec;
    t_state                 w_done_state;

    gpd_ram #(.DEPTH(MAX_ITEMS), .AW(IW), .DW(IMW)) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_im_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (w_im_wdata),
        .i_raddr (w_im_raddr),
        .o_rdata (w_im_q)
    );

    gpd_ram #(.DEPTH(MAX_ITEMS * (2 ** GW)), .AW(DAW), .DW(DPW)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_dp_we),
        .i_waddr (w_dp_waddr),
        .i_wdata (w_dp_wdata),
        .i_raddr (w_dp_raddr),
        .o_rdata (w_dp_q)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_emit;
    assign o_res.boundary_size = r_buf_q;
    assign o_res.last_boundary = r_emit_last;

    assign w_acc     = i_start && (r_state == S_IDLE);
    assign w_stored  = (r_cnt < CW'(MAX_ITEMS));
    assign w_pf_new  = (r_cnt == '0) ? PW'(i_req.item_size) : r_pf + PW'(i_req.item_size);
    assign w_issue   = (r_state == S_SCAN) && (r_j < r_row);
    assign w_improve = r_p1 && (r_v < r_best);
    assign w_kdec    = r_k - KW'(1);

    assign w_c0_prod = (SIZE_W+CW)'(r_sz) * (SIZE_W+CW)'(CW'(r_row) + CW'(1));
    assign w_c0      = $signed(VW'(w_c0_prod)) - $signed(VW'(r_pf));

    assign w_pad_prod = PW'(r_sz) * PW'(r_row - r_p0_j);
    assign w_v = VW'($signed(w_dp_q[COST_W-1:0])) + $signed(VW'(w_pad_prod))
               - $signed(VW'(r_pf)) + $signed(VW'(w_im_q[PW-1:0]));

    assign w_pos      = w_dp_q[COST_W +: IW];
    assign w_pos_none = w_dp_q[DPW-1];
    assign w_done_state = r_last ? S_TBS : S_IDLE;

    always_comb begin
        n_state = r_state;
        n_g = r_g;     n_cnt = r_cnt;   n_row = r_row;   n_sz = r_sz;
        n_pf = r_pf;   n_last = r_last; n_k = r_k;       n_j = r_j;
        n_best = r_best;  n_split = r_split;  n_none = r_none;
        n_tcnt = r_tcnt;  n_push = r_push;    n_ridx = r_ridx;
        n_p0   = w_issue;
        n_p0_j = r_j;
        n_p1   = r_p0;
        n_p1_j = r_p0_j;
        n_v    = w_v;
        w_im_we = 1'b0;
        w_im_wdata = {i_req.item_size, w_pf_new};
        w_im_raddr = r_j;
        w_dp_we = 1'b0;
        w_dp_waddr = {r_row, r_k[GW-1:0]};
        w_dp_wdata = {r_none, r_split, f_clamp(r_best)};
        w_dp_raddr = {r_j, w_kdec[GW-1:0]};
        w_tb_we = 1'b0;
        w_tb_waddr = r_tcnt[GW-1:0];
        w_tb_wdata = w_im_q[PW +: SIZE_W];
        w_tcnt_now = r_tcnt;

        if (w_improve) begin
            n_best  = r_v;
            n_split = r_p1_j;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_last = i_req.last_item;
                    if (r_cnt == '0) begin
                        if (r_cfg == '0) begin
                            n_g = KW'(1);
                        end else if (int'(r_cfg) > MAX_GROUPS) begin
                            n_g = KW'(MAX_GROUPS);
                        end else begin
                            n_g = KW'(r_cfg);
                        end
                    end
                    if (w_stored) begin
                        w_im_we = 1'b1;
                        n_row   = r_cnt[IW-1:0];
                        n_sz    = i_req.item_size;
                        n_pf    = w_pf_new;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_COL0;
                    end else if (i_req.last_item) begin
                        n_state = S_TBS;
                    end
                end
            end
            S_COL0: begin
                w_dp_we    = 1'b1;
                w_dp_waddr = {r_row, GW'(0)};
                w_dp_wdata = {1'b1, IW'(0), f_clamp(w_c0)};
                n_k        = KW'(1);
                n_state    = (r_g > KW'(1)) ? S_COLS : w_done_state;
            end
            S_COLS: begin
                n_best  = C_SENT;
                n_split = '0;
                n_none  = (r_row == '0);
                n_j     = r_ss[r_k[GW-1:0]];
                n_state = (r_row == '0) ? S_COLW : S_SCAN;
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_j = r_j + IW'(1);
                end else if (!r_p0 && !r_p1) begin
                    n_state = S_COLW;
                end
            end
            S_COLW: begin
                w_dp_we = 1'b1;
                n_k     = r_k + KW'(1);
                n_state = (r_k + KW'(1) < r_g) ? S_COLS : w_done_state;
            end
            S_TBS: begin
                w_tb_we    = 1'b1;
                w_tb_waddr = '0;
                w_tb_wdata = r_sz;
                n_tcnt     = KW'(1);
                n_k        = r_g - KW'(1);
                w_dp_raddr = {r_row, GW'(r_g - KW'(1))};
                n_push     = 1'b0;
                n_cnt      = '0;
                n_state    = S_TB;
            end
            S_TB: begin
                if (r_push) begin
                    w_tb_we    = 1'b1;
                    w_tcnt_now = r_tcnt + KW'(1);
                end
                n_tcnt = w_tcnt_now;
                if (!w_pos_none && (w_pos <= r_row) && (r_k != '0)) begin
                    w_im_raddr = w_pos;
                    w_dp_raddr = {w_pos, w_kdec[GW-1:0]};
                    n_k        = w_kdec;
                    n_push     = 1'b1;
                end else begin
                    n_push  = 1'b0;
                    n_ridx  = GW'(w_tcnt_now - KW'(1));
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ridx = r_ridx - GW'(1);
                if (r_ridx == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CFG_W'(1);
            r_g     <= KW'(1);
            r_cnt   <= '0;
            r_p0    <= 1'b0;
            r_p1    <= 1'b0;
            r_push  <= 1'b0;
            r_emit  <= 1'b0;
            r_emit_last <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            r_g     <= n_g;
            r_cnt   <= n_cnt;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_push  <= n_push;
            r_emit  <= (r_state == S_OUT);
            r_emit_last <= (r_state == S_OUT) && (r_ridx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_sz    <= n_sz;
        r_pf    <= n_pf;
        r_last  <= n_last;
        r_k     <= n_k;
        r_j     <= n_j;
        r_p0_j  <= n_p0_j;
        r_p1_j  <= n_p1_j;
        r_v     <= n_v;
        r_best  <= n_best;
        r_split <= n_split;
        r_none  <= n_none;
        r_tcnt  <= n_tcnt;
        r_ridx  <= n_ridx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && r_cnt == '0)) begin
            for (int m = 0; m < MAX_GROUPS; m++) begin
                r_ss[m] <= '0;
            end
        end else if (w_improve) begin
            r_ss[r_k[GW-1:0]] <= r_p1_j;
        end
    end

    // boundary buffer, written during traceback, read back in reverse
    always_ff @(posedge i_clk) begin
        if (w_tb_we) begin
            r_tbuf[w_tb_waddr] <= w_tb_wdata;
        end
        r_buf_q <= r_tbuf[r_ridx];
    end

    `GPD_ASSERT_NOW(a_scan_row, r_state == S_SCAN, r_row != '0, "scan on row zero")
    `GPD_ASSERT_NOW(a_drained, r_state == S_COLW, !r_p0 && !r_p1, "write before pipe drained")
    `GPD_ASSERT_NEXT(a_last_res, o_res_valid && o_res.last_boundary, !o_res_valid,
        "result after final boundary")
    `GPD_ASSERT_NOW(a_col_range, r_state == S_SCAN || r_state == S_COLS, r_k < r_g && r_k != '0,
        "column index out of range")

endmodule
